### rtl/core/mcia_pkg.sv
package mcia_pkg;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // width of the id and count ports
    localparam int PORT_W = 8;

    // controller states
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE
    } t_state;

endpackage

### rtl/core/mcia_ram.sv
module mcia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/mmu_context_id_allocator_core.sv
// a free passes through ST_FREE, where its bitmap word is read back, and then shows
// o_valid; an allocate stays in ST_ALLOC until it reads a bitmap word that is not
// all taken (one word read per cycle from the bitmap ram), then shows o_valid;
// out-of-range, shared-id and pool-empty requests answer in the next cycle. one
// request at a time, next start the cycle o_valid shows. after reset a clearing pass
// loads the bitmap word by word with busy high. the result strobe cannot be stalled.
module mmu_context_id_allocator_core #(
    parameter int NUM_CONTEXTS  = 256,
    parameter int MAP_WORD_BITS = 32   // power of two
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [mcia_pkg::PORT_W-1:0] i_release_id,
    output logic                        o_valid,
    output logic [mcia_pkg::PORT_W-1:0] o_granted_id,
    output logic                        o_got_shared,
    output logic                        o_bad_free,
    output logic [mcia_pkg::PORT_W-1:0] o_free_count
);

    import mcia_pkg::*;

    localparam int MAP_WORDS = (NUM_CONTEXTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int CNT_W     = $clog2(NUM_CONTEXTS + 1);
    localparam int SHARED_ID = NUM_CONTEXTS - 1;

    // reset image of one bitmap word: every id below the shared one is free
    function automatic logic [MAP_WORD_BITS-1:0] init_word(input logic [WORD_W-1:0] w);
        logic [MAP_WORD_BITS-1:0] v;
        logic [31:0]              base;
        base = 32'(w) << BIT_W;
        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            v[j] = (base + 32'(j)) < 32'(SHARED_ID);
        end
        return v;
    endfunction

    // index of the lowest set bit
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [MAP_WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    t_state                   r_state, n_state;
    logic [WORD_W-1:0]        r_word, n_word;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [CNT_W-1:0]         r_total, n_total;
    logic                     r_valid, n_valid;
    logic [PORT_W-1:0]        r_granted, n_granted;
    logic                     r_shared, n_shared;
    logic                     r_bad, n_bad;

    logic                     ram_wr_en;
    logic [WORD_W-1:0]        ram_wr_addr;
    logic [MAP_WORD_BITS-1:0] ram_wr_data;
    logic                     ram_rd_en;
    logic [WORD_W-1:0]        ram_rd_addr;
    logic [MAP_WORD_BITS-1:0] ram_rd_data;

    logic                     accept;
    logic [31:0]              rel_ext;
    logic                     rel_oob;
    logic                     rel_shared;
    logic                     go_alloc;
    logic                     go_free;
    logic [BIT_W-1:0]         low_bit;
    logic [MAP_WORD_BITS-1:0] one_hot;
    logic [31:0]              grant_ext;
    logic [31:0]              count_ext;
    logic                     last_init;

    // free bitmap storage
    mcia_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // request decode
    assign accept     = start && (r_state == ST_IDLE);
    assign rel_ext    = 32'(i_release_id);
    assign rel_oob    = rel_ext >= 32'(NUM_CONTEXTS);
    assign rel_shared = rel_ext == 32'(SHARED_ID);
    assign go_alloc   = accept && (i_func == FUNC_ALLOC) && (r_total != '0);
    assign go_free    = accept && (i_func == FUNC_FREE) && !rel_oob && !rel_shared;
    assign last_init  = r_word == WORD_W'(MAP_WORDS - 1);

    // word search helpers
    assign low_bit   = lowest_bit(ram_rd_data);
    assign one_hot   = {{(MAP_WORD_BITS - 1){1'b0}}, 1'b1}
                       << ((r_state == ST_FREE) ? r_bit : low_bit);
    assign grant_ext = (32'(r_word) << BIT_W) | 32'(low_bit);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (last_init) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (go_alloc) begin
                    n_state = ST_ALLOC;
                end else if (go_free) begin
                    n_state = ST_FREE;
                end
            end
            ST_ALLOC: begin
                if (ram_rd_data != '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FREE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // datapath, ram control and result words
    always_comb begin
        n_word      = r_word;
        n_bit       = r_bit;
        n_total     = r_total;
        n_valid     = 1'b0;
        n_granted   = '0;
        n_shared    = 1'b0;
        n_bad       = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_word;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        unique case (r_state)
            ST_INIT: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = init_word(r_word);
                n_word      = last_init ? '0 : r_word + WORD_W'(1);
            end
            ST_IDLE: begin
                if (go_alloc) begin
                    ram_rd_en = 1'b1;
                    n_word    = '0;
                end else if (go_free) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = WORD_W'(rel_ext >> BIT_W);
                    n_word      = WORD_W'(rel_ext >> BIT_W);
                    n_bit       = rel_ext[BIT_W-1:0];
                end else if (accept) begin
                    // pool empty, out of range or shared id: answer at once
                    n_valid = 1'b1;
                    if (i_func == FUNC_ALLOC) begin
                        n_granted = PORT_W'(SHARED_ID);
                        n_shared  = 1'b1;
                    end else begin
                        n_bad = rel_oob;
                    end
                end
            end
            ST_ALLOC: begin
                if (ram_rd_data != '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data & ~one_hot;
                    n_total     = r_total - CNT_W'(1);
                    n_valid     = 1'b1;
                    n_granted   = grant_ext[PORT_W-1:0];
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_word + WORD_W'(1);
                    n_word      = r_word + WORD_W'(1);
                end
            end
            ST_FREE: begin
                n_valid = 1'b1;
                if (ram_rd_data[r_bit]) begin
                    n_bad = 1'b1;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data | one_hot;
                    n_total     = r_total + CNT_W'(1);
                end
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_word  <= '0;
            r_total <= CNT_W'(SHARED_ID);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_granted <= n_granted;
        r_shared  <= n_shared;
        r_bad     <= n_bad;
    end

    assign count_ext    = 32'(r_total);
    assign busy         = r_state != ST_IDLE;
    assign o_valid      = r_valid;
    assign o_granted_id = r_granted;
    assign o_got_shared = r_shared;
    assign o_bad_free   = r_bad;
    assign o_free_count = count_ext[PORT_W-1:0];

endmodule

### rtl/core/mcia_checker.sv
module mcia_checker #(
    parameter int NUM_CONTEXTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       o_valid,
    input  logic [7:0] o_granted_id,
    input  logic       o_got_shared,
    input  logic       o_bad_free,
    input  logic [7:0] o_free_count
);

    localparam int SHARED_ID = NUM_CONTEXTS - 1;

    // an accepted request either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted request neither answered nor busy");

    // shared fallback only on an empty pool and with the shared id
    a_shared_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_got_shared) |->
            (o_free_count == 8'd0) && (o_granted_id == 8'(SHARED_ID)) && !o_bad_free)
        else $error("shared fallback word inconsistent");

    // a rejected free grants nothing
    a_bad_free_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_free) |-> (o_granted_id == 8'd0) && !o_got_shared)
        else $error("rejected free carries a grant");

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe after reset");

endmodule

bind mmu_context_id_allocator_core mcia_checker #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
) u_mcia_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_granted_id (o_granted_id),
    .o_got_shared (o_got_shared),
    .o_bad_free   (o_bad_free),
    .o_free_count (o_free_count)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mcia_pkg::*;

    localparam int          NUM_IDS    = 256;
    localparam logic [7:0]  SHARED_ID  = 8'd255;
    localparam int          N_RANDOM   = 450;
    localparam int          MAX_CYCLES = 200000;
    localparam int          N_TABLE    = 18;

    // one result word of the allocator
    typedef struct packed {
        logic [PORT_W-1:0] granted;
        logic              shared;
        logic              bad;
        logic [PORT_W-1:0] count;
    } t_ctx_result;

    // directed row: request plus an optional hand-written answer
    typedef struct packed {
        logic              func;
        logic [PORT_W-1:0] id;
        logic              typed;
        t_ctx_result       res;
    } t_ctx_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_func;
    logic [PORT_W-1:0] i_release_id;
    logic              o_valid;
    logic [PORT_W-1:0] o_granted_id;
    logic              o_got_shared;
    logic              o_bad_free;
    logic [PORT_W-1:0] o_free_count;

    // shadow copy of the free bitmap and free count
    logic [NUM_IDS-1:0] ctx_free_map;
    int                 ctx_free_total;

    t_ctx_result pending_results[$];
    int          fail_count;
    int          cycle_count;
    int          n_checked;
    int          n_alloc;
    int          n_free;
    int          n_shared_grants;
    int          n_bad_frees;

    // directed rows; release ids 8'hff and 8'h00 toggle every id bit
    t_ctx_row table_rows [N_TABLE] = '{
        '{FUNC_ALLOC, 8'h00, 1'b1, '{8'd0, 1'b0, 1'b0, 8'd254}},
        '{FUNC_ALLOC, 8'hff, 1'b1, '{8'd1, 1'b0, 1'b0, 8'd253}},
        '{FUNC_FREE,  8'h00, 1'b1, '{8'd0, 1'b0, 1'b0, 8'd254}},
        // double free of the same id
        '{FUNC_FREE,  8'h00, 1'b1, '{8'd0, 1'b0, 1'b1, 8'd254}},
        // shared id is never released
        '{FUNC_FREE,  8'hff, 1'b1, '{8'd0, 1'b0, 1'b0, 8'd254}},
        // highest ordinary id was never handed out
        '{FUNC_FREE,  8'hfe, 1'b1, '{8'd0, 1'b0, 1'b1, 8'd254}},
        '{FUNC_ALLOC, 8'h00, 1'b1, '{8'd0, 1'b0, 1'b0, 8'd253}},
        '{FUNC_ALLOC, 8'haa, 1'b0, '0},
        '{FUNC_ALLOC, 8'h55, 1'b0, '0},
        '{FUNC_FREE,  8'hff, 1'b1, '{8'd0, 1'b0, 1'b0, 8'd251}},
        '{FUNC_FREE,  8'h80, 1'b1, '{8'd0, 1'b0, 1'b1, 8'd251}},
        '{FUNC_FREE,  8'h01, 1'b0, '0},
        '{FUNC_ALLOC, 8'h00, 1'b0, '0},
        '{FUNC_FREE,  8'h02, 1'b0, '0},
        '{FUNC_FREE,  8'h03, 1'b0, '0},
        '{FUNC_ALLOC, 8'h7f, 1'b0, '0},
        '{FUNC_ALLOC, 8'h00, 1'b0, '0},
        '{FUNC_FREE,  8'h7f, 1'b0, '0}
    };

    mmu_context_id_allocator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_release_id (i_release_id),
        .o_valid      (o_valid),
        .o_granted_id (o_granted_id),
        .o_got_shared (o_got_shared),
        .o_bad_free   (o_bad_free),
        .o_free_count (o_free_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // next state of the allocator for one request; 8-bit ids never exceed the range
    function automatic t_ctx_result predict_context_step(input logic f,
                                                         input logic [PORT_W-1:0] id);
        t_ctx_result r;
        logic        found;
        r     = '0;
        found = 1'b0;
        if (f == FUNC_ALLOC) begin
            if (ctx_free_total != 0) begin
                for (int i = 0; i < NUM_IDS; i++) begin
                    if (!found && ctx_free_map[i]) begin
                        found           = 1'b1;
                        ctx_free_map[i] = 1'b0;
                        ctx_free_total--;
                        r.granted       = i[PORT_W-1:0];
                    end
                end
            end
            if (!found) begin
                r.granted = SHARED_ID;
                r.shared  = 1'b1;
            end
        end else if (id != SHARED_ID) begin
            if (ctx_free_map[id]) begin
                r.bad = 1'b1;
            end else begin
                ctx_free_map[id] = 1'b1;
                ctx_free_total++;
            end
        end
        r.count = ctx_free_total[PORT_W-1:0];
        return r;
    endfunction

    // random id that is currently handed out, or any id when none is
    function automatic logic [PORT_W-1:0] pick_taken_id();
        logic [PORT_W-1:0] taken[$];
        for (int i = 0; i < NUM_IDS - 1; i++) begin
            if (!ctx_free_map[i]) taken.push_back(i[PORT_W-1:0]);
        end
        if (taken.size() == 0) return PORT_W'($urandom_range(0, NUM_IDS - 1));
        return taken[$urandom_range(0, taken.size() - 1)];
    endfunction

    // drive one request word from a falling edge and hold it until accepted
    task automatic issue_request(input logic f, input logic [PORT_W-1:0] id,
                                 input logic typed, input t_ctx_result typed_res);
        t_ctx_result r;
        start        <= 1'b1;
        i_func       <= f;
        i_release_id <= id;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = predict_context_step(f, id);
        pending_results.push_back(typed ? typed_res : r);
        if (f == FUNC_ALLOC) n_alloc++;
        else n_free++;
        @(negedge i_clk);
    endtask

    // idle gap before the next request, start low meanwhile
    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_ctx_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: granted_id %0d", o_granted_id);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_got_shared) n_shared_grants++;
                if (o_bad_free) n_bad_frees++;
                if (o_granted_id !== want.granted) begin
                    $error("granted_id: expected %0d, got %0d", want.granted, o_granted_id);
                    fail_count++;
                end
                if (o_got_shared !== want.shared) begin
                    $error("got_shared: expected %0d, got %0d", want.shared, o_got_shared);
                    fail_count++;
                end
                if (o_bad_free !== want.bad) begin
                    $error("bad_free: expected %0d, got %0d", want.bad, o_bad_free);
                    fail_count++;
                end
                if (o_free_count !== want.count) begin
                    $error("free_count: expected %0d, got %0d", want.count, o_free_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        int          idle_pct;
        int          phase;
        int          shared_hits;
        logic        draining;
        logic        f;
        logic [PORT_W-1:0] id;
        int          pick;

        fail_count      = 0;
        cycle_count     = 0;
        n_checked       = 0;
        n_alloc         = 0;
        n_free          = 0;
        n_shared_grants = 0;
        n_bad_frees     = 0;
        shared_hits     = 0;
        draining        = 1'b1;
        ctx_free_map    = {1'b0, {(NUM_IDS - 1){1'b1}}};
        ctx_free_total  = NUM_IDS - 1;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_ALLOC;
        i_release_id    = '0;

        // reset, then the block clears its bitmap with busy high
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, back to back
        for (int k = 0; k < N_TABLE; k++) begin
            issue_request(table_rows[k].func, table_rows[k].id,
                          table_rows[k].typed, table_rows[k].res);
        end

        // random part: drain the pool to exhaustion, then refill, and repeat;
        // quarters: no gaps, 52% sender gaps, no gaps (result side cannot stall), 24%
        for (int n = 0; n < N_RANDOM; n++) begin
            phase    = (n * 4) / N_RANDOM;
            idle_pct = (phase == 1) ? 52 : (phase == 3) ? 24 : 0;
            sender_gap(idle_pct);

            if (draining) begin
                f = ($urandom_range(0, 99) < 92) ? FUNC_ALLOC : FUNC_FREE;
                if (f == FUNC_ALLOC && ctx_free_total == 0) shared_hits++;
                if (shared_hits >= 6) begin
                    draining    = 1'b0;
                    shared_hits = 0;
                end
            end else begin
                f = ($urandom_range(0, 99) < 85) ? FUNC_FREE : FUNC_ALLOC;
                if (ctx_free_total > 200) draining = 1'b1;
            end

            // free targets: mostly held ids, some shared id, some anything
            pick = $urandom_range(0, 99);
            if (f == FUNC_ALLOC) id = PORT_W'($urandom_range(0, NUM_IDS - 1));
            else if (pick < 70) id = pick_taken_id();
            else if (pick < 80) id = SHARED_ID;
            else id = PORT_W'($urandom_range(0, NUM_IDS - 1));

            issue_request(f, id, 1'b0, '0);
        end
        start <= 1'b0;

        // drain outstanding results, then keep watching for stray strobes
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d allocates and %0d frees, %0d result words checked",
                 n_alloc, n_free, n_checked);
        $display("pool ran dry %0d times, %0d frees were rejected",
                 n_shared_grants, n_bad_frees);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### mmu_context_id_allocator_core.f
rtl/core/mcia_pkg.sv
rtl/core/mcia_ram.sv
rtl/core/mmu_context_id_allocator_core.sv
rtl/core/mcia_checker.sv
tb/tb_top.sv
